// ===== hdl/seg_isect_pkg.sv =====
// ---------------------------------------------------------------------------
// seg_isect_pkg
// Types and widths shared by the 2D segment intersection pipeline.
// ---------------------------------------------------------------------------
package seg_isect_pkg;

  // Field widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned OUT_W   = 24;

  // Default number of fraction bits in the crossing point
  localparam int unsigned FRAC_BITS_DEFAULT = 8;

  // Internal arithmetic widths
  localparam int unsigned DIFF_W = COORD_W + 1;     // endpoint differences
  localparam int unsigned PROD_W = 2 * DIFF_W;      // difference products
  localparam int unsigned DET_W  = PROD_W + 1;      // determinants
  localparam int unsigned MAG_W  = DET_W - 1;       // |denominator|
  localparam int unsigned MUL_W  = DET_W + DIFF_W;  // tn * delta, p0 * den
  localparam int unsigned NUM_W  = MUL_W + 1;       // crossing numerator

  // Input beat: two segments
  typedef struct packed {
    logic signed [COORD_W-1:0] a_start_x;
    logic signed [COORD_W-1:0] a_start_y;
    logic signed [COORD_W-1:0] a_end_x;
    logic signed [COORD_W-1:0] a_end_y;
    logic signed [COORD_W-1:0] b_start_x;
    logic signed [COORD_W-1:0] b_start_y;
    logic signed [COORD_W-1:0] b_end_x;
    logic signed [COORD_W-1:0] b_end_y;
  } seg_pair_t;

  // Result beat: hit flag and crossing point
  typedef struct packed {
    logic                    hit;
    logic signed [OUT_W-1:0] cross_x;
    logic signed [OUT_W-1:0] cross_y;
  } cross_t;

endpackage

// ===== hdl/segment_intersection_2d.sv =====
// ---------------------------------------------------------------------------
// segment_intersection_2d
// Pipelined exact crossing test of two 2D segments with fixed-point point.
// ---------------------------------------------------------------------------
// Takes one segment pair per clock whenever start is high (busy stays low)
// and returns one result beat per pair, in order. done_o is high
// for exactly one cycle with each result and the receiver cannot stall it.
// Most of the pipeline is the two restoring dividers that form the crossing
// point: they produce one quotient bit per pipeline stage, FRAC_BITS + 16
// stages, behind the stages of differences, products and the hit test.
// Parallel or collinear segments report no hit; a miss gives zero coordinates.
// ---------------------------------------------------------------------------
module segment_intersection_2d #(
  parameter int unsigned FRAC_BITS = seg_isect_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  seg_isect_pkg::seg_pair_t seg_i,
  output logic                    done_o,
  output seg_isect_pkg::cross_t    result_o
);

  localparam int unsigned COORD_W = seg_isect_pkg::COORD_W;
  localparam int unsigned OUT_W   = seg_isect_pkg::OUT_W;
  localparam int unsigned DIFF_W  = seg_isect_pkg::DIFF_W;
  localparam int unsigned PROD_W  = seg_isect_pkg::PROD_W;
  localparam int unsigned DET_W   = seg_isect_pkg::DET_W;
  localparam int unsigned MAG_W   = seg_isect_pkg::MAG_W;
  localparam int unsigned MUL_W   = seg_isect_pkg::MUL_W;
  localparam int unsigned NUM_W   = seg_isect_pkg::NUM_W;

  // Quotient magnitude is at most 2^(COORD_W-1+FRAC_BITS), inclusive
  localparam int unsigned QW = COORD_W + FRAC_BITS;
  localparam int unsigned QS = QW + 1;

  logic accept;

  // Pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ------------------------------------------------------------------
  // Stage 0: input register
  // ------------------------------------------------------------------
  logic                     in_vld_q;
  seg_isect_pkg::seg_pair_t in_q;

  // ------------------------------------------------------------------
  // Stage 1: direction and offset vectors
  // ------------------------------------------------------------------
  logic                     s1_vld_q;
  logic signed [DIFF_W-1:0] s1_ax_q, s1_ay_q, s1_bx_q, s1_by_q, s1_ox_q, s1_oy_q;
  logic signed [DIFF_W-1:0] s1_ax_d, s1_ay_d, s1_bx_d, s1_by_d, s1_ox_d, s1_oy_d;
  logic signed [COORD_W-1:0] s1_p0x_q, s1_p0y_q;

  assign s1_ax_d = DIFF_W'(in_q.a_end_x)   - DIFF_W'(in_q.a_start_x);
  assign s1_ay_d = DIFF_W'(in_q.a_end_y)   - DIFF_W'(in_q.a_start_y);
  assign s1_bx_d = DIFF_W'(in_q.b_end_x)   - DIFF_W'(in_q.b_start_x);
  assign s1_by_d = DIFF_W'(in_q.b_end_y)   - DIFF_W'(in_q.b_start_y);
  assign s1_ox_d = DIFF_W'(in_q.a_start_x) - DIFF_W'(in_q.b_start_x);
  assign s1_oy_d = DIFF_W'(in_q.a_start_y) - DIFF_W'(in_q.b_start_y);

  // ------------------------------------------------------------------
  // Stage 2: cross products of the vectors
  // ------------------------------------------------------------------
  logic                      s2_vld_q;
  logic signed [PROD_W-1:0]  s2_axby_q, s2_bxay_q, s2_axoy_q;
  logic signed [PROD_W-1:0]  s2_ayox_q, s2_bxoy_q, s2_byox_q;
  logic signed [DIFF_W-1:0]  s2_ax_q, s2_ay_q;
  logic signed [COORD_W-1:0] s2_p0x_q, s2_p0y_q;

  // ------------------------------------------------------------------
  // Stage 3: denominator and both parameter numerators
  // ------------------------------------------------------------------
  logic                      s3_vld_q;
  logic signed [DET_W-1:0]   s3_den_q, s3_sn_q, s3_tn_q;
  logic signed [DIFF_W-1:0]  s3_ax_q, s3_ay_q;
  logic signed [COORD_W-1:0] s3_p0x_q, s3_p0y_q;

  // ------------------------------------------------------------------
  // Stage 4: make the denominator non-negative
  // ------------------------------------------------------------------
  logic                      s4_vld_q;
  logic signed [DET_W-1:0]   s4_den_q, s4_sn_q, s4_tn_q;
  logic signed [DET_W-1:0]   s4_den_d, s4_sn_d, s4_tn_d;
  logic signed [DIFF_W-1:0]  s4_ax_q, s4_ay_q;
  logic signed [COORD_W-1:0] s4_p0x_q, s4_p0y_q;

  always_comb begin
    if (s3_den_q[DET_W-1]) begin
      s4_den_d = -s3_den_q;
      s4_sn_d  = -s3_sn_q;
      s4_tn_d  = -s3_tn_q;
    end else begin
      s4_den_d = s3_den_q;
      s4_sn_d  = s3_sn_q;
      s4_tn_d  = s3_tn_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: range test and numerator products
  // ------------------------------------------------------------------
  logic                    s5_vld_q;
  logic                    s5_hit_q;
  logic                    s5_hit_d;
  logic signed [MUL_W-1:0] s5_mx_q, s5_my_q, s5_bx_q, s5_by_q;
  logic [MAG_W-1:0]        s5_den_q;

  // Both s and t in [0,1], non-zero denominator
  assign s5_hit_d = (s4_den_q != '0)
                    && !s4_sn_q[DET_W-1] && (s4_sn_q <= s4_den_q)
                    && !s4_tn_q[DET_W-1] && (s4_tn_q <= s4_den_q);

  // ------------------------------------------------------------------
  // Stage 6: crossing numerators p0 * den + tn * delta
  // ------------------------------------------------------------------
  logic                    s6_vld_q;
  logic                    s6_hit_q;
  logic signed [NUM_W-1:0] s6_nx_q, s6_ny_q;
  logic [MAG_W-1:0]        s6_den_q;

  // ------------------------------------------------------------------
  // Divider pipeline: entry 0 holds the magnitude split, entries 1..QW
  // each retire one quotient bit. acc shifts dividend bits out at the top
  // and quotient bits in at the bottom.
  // ------------------------------------------------------------------
  logic             dv_vld_q  [QW+1];
  logic             dv_hit_q  [QW+1];
  logic             dv_negx_q [QW+1];
  logic             dv_negy_q [QW+1];
  logic [MAG_W-1:0] dv_den_q  [QW+1];
  logic [MAG_W-1:0] dv_remx_q [QW+1];
  logic [MAG_W-1:0] dv_remy_q [QW+1];
  logic [QW-1:0]    dv_accx_q [QW+1];
  logic [QW-1:0]    dv_accy_q [QW+1];

  logic [NUM_W-1:0] absx_d, absy_d;

  assign absx_d = s6_nx_q[NUM_W-1] ? NUM_W'(-s6_nx_q) : NUM_W'(s6_nx_q);
  assign absy_d = s6_ny_q[NUM_W-1] ? NUM_W'(-s6_ny_q) : NUM_W'(s6_ny_q);

  // ------------------------------------------------------------------
  // Output: signed quotient, wrapped to the result width, zero on miss
  // ------------------------------------------------------------------
  logic signed [QS-1:0]  qx_mag, qy_mag, qx_s, qy_s;
  logic                  done_q;
  seg_isect_pkg::cross_t result_q, result_d;

  assign qx_mag = QS'(dv_accx_q[QW]);
  assign qy_mag = QS'(dv_accy_q[QW]);
  assign qx_s   = dv_negx_q[QW] ? -qx_mag : qx_mag;
  assign qy_s   = dv_negy_q[QW] ? -qy_mag : qy_mag;

  always_comb begin
    result_d = '0;
    if (dv_hit_q[QW]) begin
      result_d.hit     = 1'b1;
      result_d.cross_x = OUT_W'(qx_s);
      result_d.cross_y = OUT_W'(qy_s);
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      s5_vld_q    <= 1'b0;
      s6_vld_q    <= 1'b0;
      dv_vld_q[0] <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      in_vld_q    <= accept;
      s1_vld_q    <= in_vld_q;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      s4_vld_q    <= s3_vld_q;
      s5_vld_q    <= s4_vld_q;
      s6_vld_q    <= s5_vld_q;
      dv_vld_q[0] <= s6_vld_q;
      done_q      <= dv_vld_q[QW];
    end
  end

  // Front-end datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= seg_i;
    end
    // stage 1
    s1_ax_q  <= s1_ax_d;
    s1_ay_q  <= s1_ay_d;
    s1_bx_q  <= s1_bx_d;
    s1_by_q  <= s1_by_d;
    s1_ox_q  <= s1_ox_d;
    s1_oy_q  <= s1_oy_d;
    s1_p0x_q <= in_q.a_start_x;
    s1_p0y_q <= in_q.a_start_y;
    // stage 2
    s2_axby_q <= PROD_W'(s1_ax_q) * PROD_W'(s1_by_q);
    s2_bxay_q <= PROD_W'(s1_bx_q) * PROD_W'(s1_ay_q);
    s2_axoy_q <= PROD_W'(s1_ax_q) * PROD_W'(s1_oy_q);
    s2_ayox_q <= PROD_W'(s1_ay_q) * PROD_W'(s1_ox_q);
    s2_bxoy_q <= PROD_W'(s1_bx_q) * PROD_W'(s1_oy_q);
    s2_byox_q <= PROD_W'(s1_by_q) * PROD_W'(s1_ox_q);
    s2_ax_q   <= s1_ax_q;
    s2_ay_q   <= s1_ay_q;
    s2_p0x_q  <= s1_p0x_q;
    s2_p0y_q  <= s1_p0y_q;
    // stage 3
    s3_den_q <= DET_W'(s2_axby_q) - DET_W'(s2_bxay_q);
    s3_sn_q  <= DET_W'(s2_axoy_q) - DET_W'(s2_ayox_q);
    s3_tn_q  <= DET_W'(s2_bxoy_q) - DET_W'(s2_byox_q);
    s3_ax_q  <= s2_ax_q;
    s3_ay_q  <= s2_ay_q;
    s3_p0x_q <= s2_p0x_q;
    s3_p0y_q <= s2_p0y_q;
    // stage 4
    s4_den_q <= s4_den_d;
    s4_sn_q  <= s4_sn_d;
    s4_tn_q  <= s4_tn_d;
    s4_ax_q  <= s3_ax_q;
    s4_ay_q  <= s3_ay_q;
    s4_p0x_q <= s3_p0x_q;
    s4_p0y_q <= s3_p0y_q;
    // stage 5
    s5_hit_q <= s5_hit_d;
    s5_mx_q  <= MUL_W'(s4_tn_q) * MUL_W'(s4_ax_q);
    s5_my_q  <= MUL_W'(s4_tn_q) * MUL_W'(s4_ay_q);
    s5_bx_q  <= MUL_W'(s4_p0x_q) * MUL_W'(s4_den_q);
    s5_by_q  <= MUL_W'(s4_p0y_q) * MUL_W'(s4_den_q);
    s5_den_q <= s4_den_q[MAG_W-1:0];
    // stage 6
    s6_hit_q <= s5_hit_q;
    s6_nx_q  <= NUM_W'(s5_bx_q) + NUM_W'(s5_mx_q);
    s6_ny_q  <= NUM_W'(s5_by_q) + NUM_W'(s5_my_q);
    s6_den_q <= s5_den_q;
    // divider entry: high part seeds the remainder, low part the shifter
    dv_hit_q[0]  <= s6_hit_q;
    dv_negx_q[0] <= s6_nx_q[NUM_W-1];
    dv_negy_q[0] <= s6_ny_q[NUM_W-1];
    dv_den_q[0]  <= s6_den_q;
    dv_remx_q[0] <= absx_d[COORD_W +: MAG_W];
    dv_remy_q[0] <= absy_d[COORD_W +: MAG_W];
    dv_accx_q[0] <= QW'(absx_d[COORD_W-1:0]) << FRAC_BITS;
    dv_accy_q[0] <= QW'(absy_d[COORD_W-1:0]) << FRAC_BITS;
    // output
    result_q <= result_d;
  end

  // Restoring divider stages, one quotient bit each
  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [MAG_W:0]   shx, shy;
    logic [MAG_W+1:0] trx, try_v;
    logic             tkx, tky;

    assign shx   = {dv_remx_q[k-1], dv_accx_q[k-1][QW-1]};
    assign shy   = {dv_remy_q[k-1], dv_accy_q[k-1][QW-1]};
    assign trx   = {1'b0, shx}   - {2'b00, dv_den_q[k-1]};
    assign try_v = {1'b0, shy}   - {2'b00, dv_den_q[k-1]};
    assign tkx   = !trx[MAG_W+1];
    assign tky   = !try_v[MAG_W+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else begin
        dv_vld_q[k] <= dv_vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_hit_q[k]  <= dv_hit_q[k-1];
      dv_negx_q[k] <= dv_negx_q[k-1];
      dv_negy_q[k] <= dv_negy_q[k-1];
      dv_den_q[k]  <= dv_den_q[k-1];
      dv_remx_q[k] <= tkx ? trx[MAG_W-1:0] : shx[MAG_W-1:0];
      dv_remy_q[k] <= tky ? try_v[MAG_W-1:0] : shy[MAG_W-1:0];
      dv_accx_q[k] <= {dv_accx_q[k-1][QW-2:0], tkx};
      dv_accy_q[k] <= {dv_accy_q[k-1][QW-2:0], tky};
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
